// File: hw/rtl/npcm_pkg.sv
// Shared types and constants for the nearest palette color match block.
// Used by every module under hw/rtl except npcm_ram; depends on nothing.
`timescale 1ns / 1ps

package npcm_pkg;

  localparam int COMP_W     = 16;  // component field width
  localparam int IDX_W      = 8;   // palette index field width
  localparam int SCALE_W    = 16;  // maxval register width
  localparam int COUNT_W    = 9;   // entry_count register width
  localparam int PROD_W     = 32;  // component times maxval
  localparam int SQ_W       = 64;  // squared scaled difference
  localparam int PAIR_W     = 65;  // sum of two squares
  localparam int DIST_W     = 66;  // sum of three squares
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IN_MAXVAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_MAXVAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_MATCH = 1'b1;

  typedef logic [COMP_W-1:0] comp_t;
  typedef logic [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic              opcode;
    logic [IDX_W-1:0]  entry_index;
    logic [COMP_W-1:0] comp_red;
    logic [COMP_W-1:0] comp_green;
    logic [COMP_W-1:0] comp_blue;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] best_index;
    logic             exact_hit;
    logic             empty_error;
  } out_item_t;

  // Effective settings; zero maxvals already forced to one.
  typedef struct packed {
    logic [SCALE_W-1:0] pix_scale;
    logic [SCALE_W-1:0] ent_scale;
    logic [COUNT_W-1:0] entry_count;
  } cfg_t;

  // Classified request held in the queue between front and back.
  typedef struct packed {
    logic             opcode;
    logic [IDX_W-1:0] entry_index;
    comp_t [2:0]      comp;    // masked components, red at [0]
    prod_t [2:0]      scaled;  // pixel components times palette maxval
  } q_item_t;

  // Travels with each palette entry through the distance pipeline.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] index;
  } tag_t;

  typedef struct packed {
    logic searching;
    logic finishing;
  } back_stat_t;

endpackage

// File: hw/rtl/npcm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module npcm_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/npcm_dist.sv
// Five-stage pipelined squared-distance unit for one palette entry per cycle.
// Depends on npcm_pkg.
`timescale 1ns / 1ps

module npcm_dist (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           flush,
  input  npcm_pkg::tag_t                 tag_in,
  input  npcm_pkg::comp_t [2:0]          ent,
  input  npcm_pkg::prod_t [2:0]          pix,
  input  logic [npcm_pkg::SCALE_W-1:0]   ent_scale,
  output npcm_pkg::tag_t                 tag_out,
  output logic [npcm_pkg::DIST_W-1:0]    sum_sq
);

  npcm_pkg::tag_t t1, t2, t3, t4;
  npcm_pkg::prod_t [2:0] prod_ent;
  npcm_pkg::prod_t [2:0] diff;
  logic [npcm_pkg::SQ_W-1:0] sq [3];
  logic [npcm_pkg::PAIR_W-1:0] pair;
  logic [npcm_pkg::SQ_W-1:0] sq_blue;

  // Valid bits; drop everything in flight on flush.
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      t1      <= '0;
      t2      <= '0;
      t3      <= '0;
      t4      <= '0;
      tag_out <= '0;
    end else begin
      t1      <= tag_in;
      t2      <= t1;
      t3      <= t2;
      t4      <= t3;
      tag_out <= t4;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod_ent[k] <= npcm_pkg::prod_t'(ent[k]) * npcm_pkg::prod_t'(ent_scale);
      diff[k]     <= (pix[k] >= prod_ent[k]) ? (pix[k] - prod_ent[k])
                                             : (prod_ent[k] - pix[k]);
      sq[k]       <= npcm_pkg::SQ_W'(diff[k]) * npcm_pkg::SQ_W'(diff[k]);
    end
    pair    <= npcm_pkg::PAIR_W'(sq[0]) + npcm_pkg::PAIR_W'(sq[1]);
    sq_blue <= sq[2];
    sum_sq  <= npcm_pkg::DIST_W'(pair) + npcm_pkg::DIST_W'(sq_blue);
  end

endmodule

// File: hw/rtl/npcm_fifo.sv
// Two-entry request queue between the front and back parts.
// Depends on npcm_pkg.
`timescale 1ns / 1ps

module npcm_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  npcm_pkg::q_item_t wr_item,
  output logic              rd_valid,
  input  logic              rd_ready,
  output npcm_pkg::q_item_t rd_item
);

  npcm_pkg::q_item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        mem[wr_ptr] <= wr_item;
        wr_ptr      <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/npcm_front.sv
// Front part: accepts requests, masks components and prescales the pixel.
// Depends on npcm_pkg.
`timescale 1ns / 1ps

module npcm_front #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  npcm_pkg::in_item_t           in_item,
  input  logic [npcm_pkg::SCALE_W-1:0] pix_scale,
  output logic                         q_valid,
  input  logic                         q_ready,
  output npcm_pkg::q_item_t            q_item
);

  npcm_pkg::comp_t [2:0] comp;

  assign comp[0] = npcm_pkg::comp_t'(in_item.comp_red[COMPONENT_BITS-1:0]);
  assign comp[1] = npcm_pkg::comp_t'(in_item.comp_green[COMPONENT_BITS-1:0]);
  assign comp[2] = npcm_pkg::comp_t'(in_item.comp_blue[COMPONENT_BITS-1:0]);

  assign in_ready = q_ready;
  assign q_valid  = in_valid;

  always_comb begin
    q_item.opcode      = in_item.opcode;
    q_item.entry_index = in_item.entry_index;
    q_item.comp        = comp;
    for (int k = 0; k < 3; k++) begin
      q_item.scaled[k] = npcm_pkg::prod_t'(comp[k]) * npcm_pkg::prod_t'(pix_scale);
    end
  end

endmodule

// File: hw/rtl/npcm_back.sv
// Back part: writes palette entries and runs the nearest-entry search.
// Depends on npcm_pkg, npcm_ram and npcm_dist.
`timescale 1ns / 1ps

module npcm_back #(
  parameter int PALETTE_DEPTH  = 256,
  parameter int COMPONENT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  npcm_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  npcm_pkg::q_item_t    q_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output npcm_pkg::out_item_t  out_item,
  output npcm_pkg::back_stat_t stat
);

  localparam int AW    = $clog2(PALETTE_DEPTH);
  localparam int RAM_W = 3 * COMPONENT_BITS;
  localparam int EXT_W = 17;
  localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(PALETTE_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_DONE} state_t;

  state_t state;
  logic   issue_on;
  logic   have;
  logic [npcm_pkg::IDX_W-1:0]   cnt;
  logic [npcm_pkg::IDX_W-1:0]   best_idx;
  logic [npcm_pkg::DIST_W-1:0]  best_dist;
  npcm_pkg::prod_t [2:0]        pix;
  npcm_pkg::tag_t               rtag;
  npcm_pkg::out_item_t          res;

  logic [EXT_W-1:0]             count_ext;
  logic [EXT_W-1:0]             n_sat;
  logic [npcm_pkg::COUNT_W-1:0] n;
  logic [npcm_pkg::COUNT_W-1:0] n_m1_w;
  logic [npcm_pkg::IDX_W-1:0]   n_m1;
  logic [EXT_W-1:0]             wr_ext;
  logic [EXT_W-1:0]             rd_ext;
  logic                         pop;
  logic                         wr_en;
  logic                         rd_en;
  logic [RAM_W-1:0]             wr_data;
  logic [RAM_W-1:0]             rd_data;
  npcm_pkg::comp_t [2:0]        ent;
  npcm_pkg::tag_t               dtag;
  logic [npcm_pkg::DIST_W-1:0]  cur_dist;
  logic                         take;
  logic                         finish;
  logic                         out_free;

  // Entries in use, capped at the palette depth.
  assign count_ext = EXT_W'(cfg.entry_count);
  assign n_sat     = (count_ext > DEPTH_EXT) ? DEPTH_EXT : count_ext;
  assign n         = n_sat[npcm_pkg::COUNT_W-1:0];
  assign n_m1_w    = n - npcm_pkg::COUNT_W'(1);
  assign n_m1      = n_m1_w[npcm_pkg::IDX_W-1:0];

  assign q_ready = (state == ST_IDLE);
  assign pop     = q_valid && q_ready;
  assign wr_ext  = EXT_W'(q_item.entry_index);
  assign wr_en   = pop && (q_item.opcode == npcm_pkg::OP_LOAD) && (wr_ext < DEPTH_EXT);
  assign wr_data = {q_item.comp[2][COMPONENT_BITS-1:0],
                    q_item.comp[1][COMPONENT_BITS-1:0],
                    q_item.comp[0][COMPONENT_BITS-1:0]};
  assign rd_en   = (state == ST_SEARCH) && issue_on;
  assign rd_ext  = EXT_W'(cnt);

  npcm_ram #(
    .WIDTH (RAM_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_ext[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_ext[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ent[k] = npcm_pkg::comp_t'(rd_data[k*COMPONENT_BITS +: COMPONENT_BITS]);
    end
  end

  npcm_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .flush     (finish),
    .tag_in    (rtag),
    .ent       (ent),
    .pix       (pix),
    .ent_scale (cfg.ent_scale),
    .tag_out   (dtag),
    .sum_sq    (cur_dist)
  );

  // First strictly smaller distance wins, so ties keep the lower index.
  assign take     = dtag.valid && (!have || (cur_dist < best_dist));
  assign finish   = (state == ST_SEARCH) && dtag.valid &&
                    (dtag.last || (cur_dist == '0));
  assign out_free = !out_valid || out_ready;

  assign stat.searching = (state == ST_SEARCH);
  assign stat.finishing = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_on  <= 1'b0;
      have      <= 1'b0;
      rtag      <= '0;
      out_valid <= 1'b0;
    end else begin
      rtag.valid <= rd_en && !finish;
      rtag.last  <= (cnt == n_m1);
      rtag.index <= cnt;
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            case (q_item.opcode)
              npcm_pkg::OP_MATCH: begin
                pix  <= q_item.scaled;
                have <= 1'b0;
                cnt  <= '0;
                if (n == '0) begin
                  res.best_index  <= '0;
                  res.exact_hit   <= 1'b0;
                  res.empty_error <= 1'b1;
                  state           <= ST_DONE;
                end else begin
                  issue_on <= 1'b1;
                  state    <= ST_SEARCH;
                end
              end
              default: begin
                // load: the RAM write happens on the pop itself
              end
            endcase
          end
        end
        ST_SEARCH: begin
          // Stop issuing after the last entry or once the search is decided.
          if (rd_en) begin
            cnt <= cnt + npcm_pkg::IDX_W'(1);
            if ((cnt == n_m1) || finish) begin
              issue_on <= 1'b0;
            end
          end
          if (take) begin
            have      <= 1'b1;
            best_dist <= cur_dist;
            best_idx  <= dtag.index;
          end
          if (finish) begin
            res.best_index  <= take ? dtag.index : best_idx;
            res.exact_hit   <= ((take ? cur_dist : best_dist) == '0);
            res.empty_error <= 1'b0;
            state           <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_item  <= res;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/nearest_palette_color_match.sv
// Top level of the nearest palette color match block: configuration
// registers, front part, request queue and back part.
// Depends on npcm_pkg, npcm_front, npcm_fifo and npcm_back.
`timescale 1ns / 1ps

// Keeps a palette of up to PALETTE_DEPTH RGB entries and, for each match
// request, returns the lowest-indexed entry at least squared distance from
// the pixel, after scaling the pixel by map_maxval and the entries by
// in_maxval (done exactly by cross-multiplying). A load request writes one
// entry and produces no result; a match request produces exactly one result.
// Timing: a load is done with its RAM write on the pop. A match walks entries
// 0 .. n-1 (n is entry_count capped at the depth) through the palette RAM
// read port, one entry per cycle, into a five-stage distance pipeline, and
// the search ends at the last entry or early at an exact hit, with the
// result passing through ST_DONE into the result register. An empty palette
// skips the search and gives its result (empty_error set) from ST_DONE. The
// single RAM read port sets the one-entry-per-cycle walk. A two-entry queue
// lets new requests be accepted while a search runs, and the result register
// holds a result until it is taken. The palette RAM is not cleared: only
// loaded entries may be searched. Write configuration only while the block
// is idle.
module nearest_palette_color_match #(
  parameter int PALETTE_DEPTH  = 256,
  parameter int COMPONENT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  npcm_pkg::in_item_t              in_item,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output npcm_pkg::out_item_t             out_item,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [npcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [npcm_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [npcm_pkg::SCALE_W-1:0] in_maxval;
  logic [npcm_pkg::SCALE_W-1:0] map_maxval;
  logic [npcm_pkg::COUNT_W-1:0] entry_count;
  logic                         cfg_write;
  npcm_pkg::cfg_t               cfg;

  logic                 fq_valid;
  logic                 fq_ready;
  npcm_pkg::q_item_t    fq_item;
  logic                 bq_valid;
  logic                 bq_ready;
  npcm_pkg::q_item_t    bq_item;
  npcm_pkg::back_stat_t stat;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_maxval   <= npcm_pkg::SCALE_W'(255);
      map_maxval  <= npcm_pkg::SCALE_W'(255);
      entry_count <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        npcm_pkg::REG_IN_MAXVAL:   in_maxval   <= cfg_data;
        npcm_pkg::REG_MAP_MAXVAL:  map_maxval  <= cfg_data;
        npcm_pkg::REG_ENTRY_COUNT: entry_count <= cfg_data[npcm_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pixel components scale by the palette maxval and entries by the pixel
  // maxval; a zero maxval counts as one.
  assign cfg.pix_scale   = (map_maxval == '0) ? npcm_pkg::SCALE_W'(1) : map_maxval;
  assign cfg.ent_scale   = (in_maxval == '0) ? npcm_pkg::SCALE_W'(1) : in_maxval;
  assign cfg.entry_count = entry_count;

  npcm_front #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .pix_scale (cfg.pix_scale),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_item    (fq_item)
  );

  npcm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_item  (bq_item)
  );

  npcm_back #(
    .PALETTE_DEPTH  (PALETTE_DEPTH),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (bq_valid),
    .q_ready   (bq_ready),
    .q_item    (bq_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .stat      (stat)
  );

  // A new result appears only after the back part has finished a request.
  a_result_follows_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stat.finishing))
    else $error("result appeared without a finished request");

  // Hold the queue while a search runs.
  a_no_pop_in_search: assert property (@(posedge clk) disable iff (rst)
    stat.searching |-> !bq_ready)
    else $error("queue popped during a search");

  // An empty palette result carries a zero index and no exact hit.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.empty_error) |->
      (out_item.best_index == '0 && !out_item.exact_hit))
    else $error("empty palette result with index or hit set");

endmodule

// File: bench/palette_match_checker.sv
// Checker for the nearest palette color match block: watches the request,
// result and register channels, predicts each result and compares it.
// Depends on npcm_pkg for the channel types, register indexes and opcodes.
`timescale 1ns / 1ps

module palette_match_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  npcm_pkg::in_item_t              in_item,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  npcm_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [npcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [npcm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending
);

  localparam int DEPTH = 256;

  logic [2:0][npcm_pkg::COMP_W-1:0] swatch [DEPTH];  // red at [0]
  logic [npcm_pkg::SCALE_W-1:0]     in_maxval_q;
  logic [npcm_pkg::SCALE_W-1:0]     map_maxval_q;
  logic [npcm_pkg::COUNT_W-1:0]     count_q;
  npcm_pkg::out_item_t              results_due [$];
  int                               errs;

  // First entry at least scaled squared distance; stop at an exact hit.
  function automatic npcm_pkg::out_item_t nearest_entry(input npcm_pkg::in_item_t px);
    npcm_pkg::out_item_t              res;
    logic [2:0][npcm_pkg::COMP_W-1:0] pix;
    logic [npcm_pkg::PROD_W-1:0]      pix_scale, ent_scale, a, b, d;
    logic [npcm_pkg::DIST_W-1:0]      cand_dist, best_dist;
    int                               n;
    pix = {px.comp_blue, px.comp_green, px.comp_red};
    pix_scale = (map_maxval_q == '0) ? npcm_pkg::PROD_W'(1)
                                     : npcm_pkg::PROD_W'(map_maxval_q);
    ent_scale = (in_maxval_q == '0) ? npcm_pkg::PROD_W'(1)
                                    : npcm_pkg::PROD_W'(in_maxval_q);
    n = (count_q > DEPTH) ? DEPTH : int'(count_q);
    res = '0;
    if (n == 0) begin
      res.empty_error = 1'b1;
      return res;
    end
    best_dist = '1;  // above any real distance, so entry 0 always takes it
    for (int i = 0; i < n; i++) begin
      cand_dist = '0;
      for (int k = 0; k < 3; k++) begin
        a = npcm_pkg::PROD_W'(pix[k]) * pix_scale;
        b = npcm_pkg::PROD_W'(swatch[i][k]) * ent_scale;
        d = (a >= b) ? a - b : b - a;
        cand_dist = cand_dist + npcm_pkg::DIST_W'(d) * npcm_pkg::DIST_W'(d);
      end
      if (cand_dist < best_dist) begin
        best_dist = cand_dist;
        res.best_index = npcm_pkg::IDX_W'(i);
      end
      if (best_dist == 0) break;
    end
    res.exact_hit = (best_dist == 0);
    return res;
  endfunction

  always @(posedge clk) begin
    npcm_pkg::out_item_t want;
    if (rst) begin
      in_maxval_q = npcm_pkg::SCALE_W'(255);
      map_maxval_q = npcm_pkg::SCALE_W'(255);
      count_q = '0;
      results_due.delete();
      errs = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          npcm_pkg::REG_IN_MAXVAL:   in_maxval_q = cfg_data;
          npcm_pkg::REG_MAP_MAXVAL:  map_maxval_q = cfg_data;
          npcm_pkg::REG_ENTRY_COUNT: count_q = cfg_data[npcm_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with none expected: index %0d hit %0b empty %0b", $time,
                   out_item.best_index, out_item.exact_hit, out_item.empty_error);
          errs++;
        end else begin
          want = results_due.pop_front();
          if (out_item.best_index !== want.best_index) begin
            $display("%0t: best_index expected %0d, got %0d", $time,
                     want.best_index, out_item.best_index);
            errs++;
          end
          if (out_item.exact_hit !== want.exact_hit) begin
            $display("%0t: exact_hit expected %0b, got %0b", $time,
                     want.exact_hit, out_item.exact_hit);
            errs++;
          end
          if (out_item.empty_error !== want.empty_error) begin
            $display("%0t: empty_error expected %0b, got %0b", $time,
                     want.empty_error, out_item.empty_error);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_item.opcode == npcm_pkg::OP_LOAD)
          swatch[in_item.entry_index] = {in_item.comp_blue, in_item.comp_green,
                                         in_item.comp_red};
        else
          results_due.push_back(nearest_entry(in_item));
      end
    end
    mismatches <= errs;
    pending <= results_due.size();
  end

endmodule

// File: bench/testbench.sv
// Top of the bench for the nearest palette color match block: clock, reset,
// request and register stimulus, result back-pressure and the verdict.
// Depends on npcm_pkg, nearest_palette_color_match and palette_match_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int RUN_LIMIT    = 1_500_000;  // cycles before the run is called hung
  localparam int TAIL_CYCLES  = 20;         // a load or an empty match may still be in flight
  localparam int HOLD_CYCLES  = 400;        // long result stall, fills the request queue
  localparam int RANDOM_ITEMS = 1100;
  localparam int DEPTH        = 256;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [npcm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic [2:0][npcm_pkg::COMP_W-1:0] rgb_t;  // red at [0]

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  npcm_pkg::in_item_t              in_item;
  logic                            out_valid;
  logic                            out_ready;
  npcm_pkg::out_item_t             out_item;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [npcm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [npcm_pkg::CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int pending;
  int cycles = 0;

  // Stimulus-side knowledge of the palette: which slots hold something and
  // what, so that searches never reach an empty slot and exact hits happen.
  rgb_t       shade [DEPTH];
  bit [255:0] filled;

  bit calm;        // no idling on either side while set
  int hold_asks;   // bumped by the stimulus to ask for a long result stall
  int hold_done;   // bumped by the receiver when a stall is over
  int sent;        // random-part requests issued so far

  nearest_palette_color_match dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  palette_match_checker match_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up on a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("%0t: run limit hit, %0d results still missing", $time, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: drop ready at random, about 9 times in 100, hold it low for a long
  // stretch when asked, and keep it high throughout a calm phase.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done++;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 9);
      end
    end
  end

  // Mostly random 16-bit values, with the two extremes kept frequent.
  function automatic logic [npcm_pkg::COMP_W-1:0] any_comp();
    case ($urandom_range(6))
      0: return '0;
      1: return '1;
      default: return npcm_pkg::COMP_W'($urandom);
    endcase
  endfunction

  function automatic rgb_t any_color();
    return {any_comp(), any_comp(), any_comp()};
  endfunction

  function automatic logic [npcm_pkg::SCALE_W-1:0] any_scale();
    case ($urandom_range(7))
      0: return '0;   // treated as one by the block
      1: return npcm_pkg::SCALE_W'(1);
      2: return '1;
      3: return npcm_pkg::SCALE_W'(255);
      default: return npcm_pkg::SCALE_W'($urandom);
    endcase
  endfunction

  // Pixel aimed at the live part of the palette: an exact copy of an entry,
  // a copy nudged by a step or two, or anything at all.
  function automatic rgb_t near_color(input int cap);
    rgb_t rgb;
    if (cap == 0) return any_color();
    rgb = shade[$urandom_range(cap - 1)];
    case ($urandom_range(9))
      0, 1, 2, 3: ;
      4, 5, 6: for (int k = 0; k < 3; k++)
        rgb[k] = rgb[k] + npcm_pkg::COMP_W'($urandom_range(4)) - npcm_pkg::COMP_W'(2);
      default: rgb = any_color();
    endcase
    return rgb;
  endfunction

  // Offer one request from a falling edge; idle first at random. Return at
  // the falling edge after it was taken, with valid still high.
  task automatic push_request(input npcm_pkg::in_item_t req);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic load_entry(input int slot, input rgb_t rgb);
    npcm_pkg::in_item_t req;
    req.opcode = npcm_pkg::OP_LOAD;
    req.entry_index = npcm_pkg::IDX_W'(slot);
    req.comp_red = rgb[0];
    req.comp_green = rgb[1];
    req.comp_blue = rgb[2];
    shade[slot] = rgb;
    filled[slot] = 1'b1;
    push_request(req);
  endtask

  // The index field means nothing to a match; fill it with noise.
  task automatic match_pixel(input rgb_t rgb);
    npcm_pkg::in_item_t req;
    req.opcode = npcm_pkg::OP_MATCH;
    req.entry_index = npcm_pkg::IDX_W'($urandom);
    req.comp_red = rgb[0];
    req.comp_green = rgb[1];
    req.comp_blue = rgb[2];
    push_request(req);
  endtask

  // Leaves cfg_valid high so back-to-back writes need no lowering.
  task automatic write_reg(input logic [npcm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [npcm_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(input logic [npcm_pkg::SCALE_W-1:0] in_mv,
                           input logic [npcm_pkg::SCALE_W-1:0] map_mv,
                           input logic [npcm_pkg::CFG_DATA_W-1:0] count_word);
    write_reg(npcm_pkg::REG_IN_MAXVAL, in_mv);
    write_reg(npcm_pkg::REG_MAP_MAXVAL, map_mv);
    write_reg(npcm_pkg::REG_ENTRY_COUNT, count_word);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every outstanding result, then let a trailing
  // load or empty match clear the back part before registers are touched.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int                           phase;
    int                           cap;
    int                           len;
    int                           pick;
    int                           slot;
    logic [npcm_pkg::SCALE_W-1:0] in_mv;
    logic [npcm_pkg::SCALE_W-1:0] map_mv;
    logic [npcm_pkg::COUNT_W-1:0] count9;

    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_asks = 0;
    hold_done = 0;
    sent = 0;
    filled = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Empty palette out of reset, before and after loads.
    match_pixel({3{16'hFFFF}});
    load_entry(0, '0);
    load_entry(1, {3{16'hFFFF}});
    load_entry(2, '0);                             // duplicate of slot 0: tie
    load_entry(3, {16'hFFFF, 16'h1234, 16'h8000});
    load_entry(DEPTH - 1, {16'h0F0F, 16'h5555, 16'hAAAA});
    match_pixel('0);
    drain();

    // Full-scale maxvals on both sides, four live entries.
    write_reg(REG_UNUSED, 16'hFFFF);
    configure(16'hFFFF, 16'hFFFF, 16'd4);
    match_pixel('0);                               // exact at the lowest tied slot
    match_pixel({3{16'hFFFF}});
    match_pixel({3{16'h0001}});                    // tie between slots 0 and 2
    match_pixel({16'hFFFF, 16'h1234, 16'h8000});
    match_pixel({16'hFFFE, 16'h1233, 16'h7FFF});
    match_pixel({16'hFFFF, 16'h0000, 16'h0000});
    drain();

    // Zero maxvals stand for one.
    configure(16'h0000, 16'hFFFF, 16'd4);
    match_pixel('0);
    match_pixel({3{16'h0001}});
    drain();
    configure(16'hFFFF, 16'h0000, 16'd2);
    match_pixel({3{16'hFFFF}});
    match_pixel({16'h0001, 16'h0000, 16'h0000});
    drain();

    // Random phases: pick a palette size, make sure every slot it covers
    // holds something, set the registers, then stream mostly matches with
    // loads mixed in. A few phases are forced so that an empty palette, the
    // full depth and a count beyond the depth always occur.
    for (phase = 0; sent < RANDOM_ITEMS; phase++) begin
      pick = $urandom_range(99);
      if (phase == 2 || pick < 6)
        count9 = '0;
      else if (phase == 5 || pick < 12)
        count9 = npcm_pkg::COUNT_W'(DEPTH);
      else if (phase == 12 || pick < 16)
        count9 = npcm_pkg::COUNT_W'($urandom_range(511, DEPTH + 1));
      else if (pick < 30)
        count9 = npcm_pkg::COUNT_W'($urandom_range(64, 17));
      else
        count9 = npcm_pkg::COUNT_W'($urandom_range(16, 1));
      cap = (count9 > DEPTH) ? DEPTH : int'(count9);

      for (slot = 0; slot < cap; slot++) begin
        if (!filled[slot]) begin
          load_entry(slot, any_color());
          sent++;
        end
      end
      drain();

      case ($urandom_range(3))
        0: begin
          in_mv = npcm_pkg::SCALE_W'(255);
          map_mv = npcm_pkg::SCALE_W'(255);
        end
        1: begin
          in_mv = any_scale();
          map_mv = in_mv;
        end
        default: begin
          in_mv = any_scale();
          map_mv = any_scale();
        end
      endcase
      // Junk above the count field must be dropped by the register.
      configure(in_mv, map_mv, {($urandom_range(3) == 0) ? 7'($urandom) : 7'd0, count9});

      calm = (phase == 6);
      if (phase == 3 || phase == 14) hold_asks++;

      len = $urandom_range(60, 20);
      repeat (len) begin
        pick = $urandom_range(99);
        if (pick < ((cap > 0) ? 80 : 60))
          match_pixel(near_color(cap));
        else
          load_entry($urandom_range(DEPTH - 1), any_color());
        sent++;
      end
    end

    drain();
    if (mismatches == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
